### hw/rtl/rzc_pkg.sv
// ----------------------------------------------------------------------------
// rzc_pkg
// Types and constants shared by the rectangular zone classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rzc_pkg;

	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_MIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_MAX_X   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_MIN_Y   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_MAX_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ZONES = 3'd4;

	// request codes
	localparam logic REQ_RESOLVE = 1'b0;
	localparam logic REQ_WRITE   = 1'b1;

	// zone kinds
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_IGNORE = 3'd1;

	typedef struct packed {
		logic              req_type;
		logic signed [31:0] x_mm;
		logic signed [31:0] y_mm;
		logic [7:0]        previous_zone;
		logic [3:0]        slot;
		logic              entry_enabled;
		logic [7:0]        entry_id;
		logic [2:0]        entry_kind;
		logic [15:0]       entry_margin;
		logic signed [31:0] rect_max_x;
		logic signed [31:0] rect_max_y;
	} req_t;

	typedef struct packed {
		logic       in_area;
		logic [7:0] zone_id;
		logic [2:0] zone_kind;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] x1;
		logic signed [31:0] y0;
		logic signed [31:0] y1;
	} rect_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  id;
		logic [2:0]  kind;
		logic [15:0] margin;
		rect_t       rect;
	} zone_t;

endpackage

`default_nettype wire

### hw/rtl/rect_zone_classifier.sv
// ----------------------------------------------------------------------------
// rect_zone_classifier
// Classifies a point into rectangular zones held in a table loaded by write
// words; room bounds and scan length come from configuration registers.
// ----------------------------------------------------------------------------
// write word: entry written on acceptance, zero result passes the done state to the output
// resolve word: room check, then up to three scans of the first N = min(active_zones,
//   MAX_ZONES) entries (ignore, previous id, first hit), then the done state to the output
// one word at a time: req_stall is high until the result is in the output register
// reset clears registers, table valid bits and sequencer; table contents stay
`default_nettype none

module rect_zone_classifier
	import rzc_pkg::*;
#(
	parameter int MAX_ZONES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_t                      rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int CW = $clog2(MAX_ZONES + 1);
	localparam int NW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOM,
		ST_IGN,
		ST_PREV,
		ST_FIRST,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      rd_idx_q;
	logic               ev_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	logic signed [31:0] pt_x_q, pt_y_q;
	logic [7:0]         prev_q;
	rect_t              room_q;
	logic [4:0]         act_q;

	logic          req_acc;
	logic          wr_en;
	logic [CW-1:0] scan_n;
	logic          scanning, issue, exhausted;
	zone_t         wr_entry, ent;
	rect_t         cmp_rect;
	logic [15:0]   cmp_margin;
	logic          hit;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign scan_n = (NW'(act_q) > NW'(MAX_ZONES)) ? CW'(MAX_ZONES) : CW'(act_q);

	// slots beyond the table are dropped
	assign wr_en = req_acc && (req.req_type == REQ_WRITE) && (NW'(req.slot) < NW'(MAX_ZONES));

	always_comb begin
		wr_entry.en      = req.entry_enabled;
		wr_entry.id      = req.entry_id;
		wr_entry.kind    = req.entry_kind;
		wr_entry.margin  = req.entry_margin;
		wr_entry.rect.x0 = req.x_mm;
		wr_entry.rect.x1 = req.rect_max_x;
		wr_entry.rect.y0 = req.y_mm;
		wr_entry.rect.y1 = req.rect_max_y;
	end

	assign scanning  = (state_q == ST_IGN) || (state_q == ST_PREV) || (state_q == ST_FIRST);
	assign issue     = scanning && (rd_idx_q < scan_n);
	// nothing left to read and nothing in flight
	assign exhausted = !ev_q && !issue;

	rzc_table #(
		.MAX_ZONES(MAX_ZONES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (AW'(req.slot)),
		.wr_entry (wr_entry),
		.rd_en    (issue),
		.rd_addr  (rd_idx_q[AW-1:0]),
		.rd_entry (ent)
	);

	// the room check and every table entry go through the same comparator
	assign cmp_rect   = (state_q == ST_ROOM) ? room_q : ent.rect;
	assign cmp_margin = (state_q == ST_PREV) ? ent.margin : 16'd0;

	rzc_cmp u_cmp (
		.x      (pt_x_q),
		.y      (pt_y_q),
		.rect   (cmp_rect),
		.margin (cmp_margin),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			ev_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			pt_x_q      <= '0;
			pt_y_q      <= '0;
			prev_q      <= '0;
			room_q      <= '0;
			act_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROOM_MIN_X:   room_q.x0 <= cfg_data;
					CFG_ROOM_MAX_X:   room_q.x1 <= cfg_data;
					CFG_ROOM_MIN_Y:   room_q.y0 <= cfg_data;
					CFG_ROOM_MAX_Y:   room_q.y1 <= cfg_data;
					CFG_ACTIVE_ZONES: act_q     <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			ev_q <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.req_type == REQ_WRITE) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							pt_x_q  <= req.x_mm;
							pt_y_q  <= req.y_mm;
							prev_q  <= req.previous_zone;
							state_q <= ST_ROOM;
						end
					end
				end
				ST_ROOM: begin
					rd_idx_q <= '0;
					ev_q     <= 1'b0;
					if (hit) begin
						state_q <= ST_IGN;
					end else begin
						res_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_IGN: begin
					if (ev_q && ent.en && (ent.kind == KIND_IGNORE) && hit) begin
						res_q   <= '0;
						state_q <= ST_DONE;
					end else if (exhausted) begin
						rd_idx_q <= '0;
						ev_q     <= 1'b0;
						state_q  <= (prev_q != 8'd0) ? ST_PREV : ST_FIRST;
					end
				end
				ST_PREV: begin
					// first enabled entry with the previous id decides, sticky or not
					if (ev_q && ent.en && (ent.id == prev_q)) begin
						if ((ent.kind != KIND_IGNORE) && hit) begin
							res_q   <= '{in_area: 1'b1, zone_id: ent.id, zone_kind: ent.kind};
							state_q <= ST_DONE;
						end else begin
							rd_idx_q <= '0;
							ev_q     <= 1'b0;
							state_q  <= ST_FIRST;
						end
					end else if (exhausted) begin
						rd_idx_q <= '0;
						ev_q     <= 1'b0;
						state_q  <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					if (ev_q && ent.en && (ent.kind != KIND_IGNORE) && hit) begin
						res_q   <= '{in_area: 1'b1, zone_id: ent.id, zone_kind: ent.kind};
						state_q <= ST_DONE;
					end else if (exhausted) begin
						res_q   <= '{in_area: 1'b1, zone_id: 8'd0, zone_kind: KIND_NONE};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_not_in_area_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.in_area || ((rsp.zone_id == 8'd0) && (rsp.zone_kind == KIND_NONE))))
		else $error("result outside area carries a zone");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.req_type == REQ_WRITE)) |=> (state_q == ST_DONE))
		else $error("write word did not go straight to result");

	a_resolve_room: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.req_type == REQ_RESOLVE)) |=> (state_q == ST_ROOM))
		else $error("resolve word did not start with the room check");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(rd_idx_q) <= NW'(MAX_ZONES))
		else $error("table read index beyond table");

endmodule

`default_nettype wire

### hw/rtl/rzc_table.sv
// ----------------------------------------------------------------------------
// rzc_table
// Zone table: one write port, one registered read port, per-entry valid bits
// so that entries not yet written read as disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module rzc_table
	import rzc_pkg::*;
#(
	parameter int MAX_ZONES = 16,
	localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire zone_t         wr_entry,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output zone_t              rd_entry
);

	zone_t                mem [MAX_ZONES];
	zone_t                rd_q;
	logic [MAX_ZONES-1:0] vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// an entry never written counts as disabled
	always_comb begin
		rd_entry    = rd_q;
		rd_entry.en = rd_q.en & rd_vld_q;
	end

endmodule

`default_nettype wire

### hw/rtl/rzc_cmp.sv
// ----------------------------------------------------------------------------
// rzc_cmp
// Shared containment test: point against a rectangle widened by a margin,
// all in 34-bit signed arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rzc_cmp
	import rzc_pkg::*;
(
	input  wire logic signed [31:0] x,
	input  wire logic signed [31:0] y,
	input  wire rect_t              rect,
	input  wire logic [15:0]        margin,
	output logic                    hit
);

	logic signed [33:0] xs, ys, mg;
	logic signed [33:0] x_lo, x_hi, y_lo, y_hi;

	always_comb begin
		xs   = $signed({{2{x[31]}}, x});
		ys   = $signed({{2{y[31]}}, y});
		mg   = $signed({18'b0, margin});
		x_lo = $signed({{2{rect.x0[31]}}, rect.x0}) - mg;
		x_hi = $signed({{2{rect.x1[31]}}, rect.x1}) + mg;
		y_lo = $signed({{2{rect.y0[31]}}, rect.y0}) - mg;
		y_hi = $signed({{2{rect.y1[31]}}, rect.y1}) + mg;
		hit  = (xs >= x_lo) && (xs <= x_hi) && (ys >= y_lo) && (ys <= y_hi);
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rectangular zone classifier. A queue-fed driver
// offers zone writes and point resolves, an in-bench predictor keeps its own
// zone table and room bounds, and a monitor checks every result word in order
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import rzc_pkg::*;

	localparam int TBL_DEPTH = 16;
	localparam int DRAIN_CYCLES = 3 * TBL_DEPTH + 10;
	localparam logic [31:0] MIN_MM = 32'h8000_0000;
	localparam logic [31:0] MAX_MM = 32'h7fff_ffff;
	localparam logic [2:0] KIND_FIRST_USER = 3'd2;

	typedef struct {
		req_t w;
		bit   drain;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	req_t req = '0;
	logic rsp_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic req_stall;
	logic rsp_valid;
	logic cfg_ready;
	rsp_t rsp;

	rect_zone_classifier #(.MAX_ZONES(TBL_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the table and registers
	zone_t zone_tbl [TBL_DEPTH];
	logic signed [31:0] room_x0, room_x1, room_y0, room_y1;
	logic [4:0] scan_len;

	pend_t pend_q[$];
	rsp_t classes_due[$];
	logic [7:0] gen_ids [TBL_DEPTH];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int n_writes = 0;
	int n_resolves = 0;
	int n_in_area = 0;
	int n_zoned = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit in_box(longint x, longint y, longint x0, longint x1,
			longint y0, longint y1, longint h);
		return x >= x0 - h && x <= x1 + h && y >= y0 - h && y <= y1 + h;
	endfunction

	function automatic bit zone_holds(int i, longint x, longint y, longint h);
		return in_box(x, y, $signed(zone_tbl[i].rect.x0), $signed(zone_tbl[i].rect.x1),
			$signed(zone_tbl[i].rect.y0), $signed(zone_tbl[i].rect.y1), h);
	endfunction

	// works out the result word and applies table writes
	function automatic rsp_t classify(req_t w);
		rsp_t r;
		longint px, py;
		int n;
		bit seen;
		r = '0;
		if (w.req_type == REQ_WRITE) begin
			zone_tbl[w.slot].en = w.entry_enabled;
			zone_tbl[w.slot].id = w.entry_id;
			zone_tbl[w.slot].kind = w.entry_kind;
			zone_tbl[w.slot].margin = w.entry_margin;
			zone_tbl[w.slot].rect.x0 = w.x_mm;
			zone_tbl[w.slot].rect.x1 = w.rect_max_x;
			zone_tbl[w.slot].rect.y0 = w.y_mm;
			zone_tbl[w.slot].rect.y1 = w.rect_max_y;
			return r;
		end
		px = $signed(w.x_mm);
		py = $signed(w.y_mm);
		n = (scan_len > TBL_DEPTH) ? TBL_DEPTH : scan_len;
		if (!in_box(px, py, room_x0, room_x1, room_y0, room_y1, 0))
			return r;
		for (int i = 0; i < n; i++)
			if (zone_tbl[i].en && zone_tbl[i].kind == KIND_IGNORE && zone_holds(i, px, py, 0))
				return r;
		r.in_area = 1'b1;
		seen = 1'b0;
		// sticky zone: only the first enabled entry with that id counts
		if (w.previous_zone != 8'd0) begin
			for (int i = 0; i < n; i++) begin
				if (!seen && zone_tbl[i].en && zone_tbl[i].id == w.previous_zone) begin
					seen = 1'b1;
					if (zone_tbl[i].kind != KIND_IGNORE
							&& zone_holds(i, px, py, zone_tbl[i].margin)) begin
						r.zone_id = zone_tbl[i].id;
						r.zone_kind = zone_tbl[i].kind;
						return r;
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			if (zone_tbl[i].en && zone_tbl[i].kind != KIND_IGNORE && zone_holds(i, px, py, 0)) begin
				r.zone_id = zone_tbl[i].id;
				r.zone_kind = zone_tbl[i].kind;
				return r;
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		pend_t nxt;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				classes_due.push_back(classify(req));
				if (req.req_type == REQ_WRITE)
					n_writes++;
				else
					n_resolves++;
			end
			if (req_valid && req_stall) begin
				// held word stays put
			end else if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& (!pend_q[0].drain || classes_due.size() == 0)) begin
				nxt = pend_q.pop_front();
				req_valid <= 1'b1;
				req <= nxt.w;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (classes_due.size() == 0) begin
					$error("result word with nothing outstanding: %h", rsp);
					err_count++;
				end else begin
					want = classes_due.pop_front();
					if (rsp.in_area !== want.in_area) begin
						$error("in_area: expected %0d, got %0d", want.in_area, rsp.in_area);
						err_count++;
					end
					if (rsp.zone_id !== want.zone_id) begin
						$error("zone_id: expected %0d, got %0d", want.zone_id, rsp.zone_id);
						err_count++;
					end
					if (rsp.zone_kind !== want.zone_kind) begin
						$error("zone_kind: expected %0d, got %0d", want.zone_kind, rsp.zone_kind);
						err_count++;
					end
					if (want.in_area)
						n_in_area++;
					if (want.zone_id != 8'd0 || want.zone_kind != KIND_NONE)
						n_zoned++;
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic int srange(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic req_t noise_word();
		logic [191:0] noise;
		req_t w;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		w = noise[$bits(req_t)-1:0];
		return w;
	endfunction

	function automatic req_t mk_resolve(logic [31:0] x, logic [31:0] y, logic [7:0] prev);
		req_t w;
		w = noise_word();
		w.req_type = REQ_RESOLVE;
		w.x_mm = x;
		w.y_mm = y;
		w.previous_zone = prev;
		return w;
	endfunction

	function automatic req_t mk_write(logic [3:0] slot, logic en, logic [7:0] id,
			logic [2:0] kind, logic [15:0] margin, logic [31:0] x0, logic [31:0] x1,
			logic [31:0] y0, logic [31:0] y1);
		req_t w;
		w = noise_word();
		w.req_type = REQ_WRITE;
		w.slot = slot;
		w.entry_enabled = en;
		w.entry_id = id;
		w.entry_kind = kind;
		w.entry_margin = margin;
		w.x_mm = x0;
		w.rect_max_x = x1;
		w.y_mm = y0;
		w.rect_max_y = y1;
		return w;
	endfunction

	function automatic logic [31:0] pick_coord(int spread);
		case ($urandom_range(19))
			0: begin
				case ($urandom_range(3))
					0: return MIN_MM;
					1: return MAX_MM;
					2: return 32'hffff_ffff;
					default: return 32'd0;
				endcase
			end
			1: return $urandom;
			default: return srange(-spread, spread);
		endcase
	endfunction

	function automatic req_t rand_zone_write();
		int x0, y0, r;
		logic [31:0] ax0, ax1, ay0, ay1;
		logic [3:0] slot;
		logic [7:0] id;
		logic [2:0] kind;
		logic [15:0] margin;
		if ($urandom_range(9) == 0) begin
			ax0 = $urandom;
			ax1 = $urandom;
			ay0 = $urandom;
			ay1 = $urandom;
		end else begin
			// mostly small rectangles, now and then empty ones
			x0 = srange(-1000, 1000);
			y0 = srange(-1000, 1000);
			ax0 = x0;
			ax1 = x0 + srange(-60, 600);
			ay0 = y0;
			ay1 = y0 + srange(-60, 600);
		end
		slot = $urandom_range(TBL_DEPTH - 1);
		r = $urandom_range(99);
		id = (r < 60) ? 8'(srange(1, 12)) : (r < 70) ? 8'd0 : 8'($urandom);
		r = $urandom_range(99);
		kind = (r < 22) ? KIND_IGNORE : (r < 32) ? KIND_NONE : 3'($urandom_range(7));
		r = $urandom_range(99);
		margin = (r < 70) ? 16'(srange(0, 200)) : (r < 90) ? 16'($urandom) : 16'd0;
		gen_ids[slot] = id;
		return mk_write(slot, ($urandom_range(99) < 85), id, kind, margin, ax0, ax1, ay0, ay1);
	endfunction

	function automatic req_t rand_point();
		int r;
		logic [7:0] prev;
		r = $urandom_range(99);
		if (r < 45)
			prev = gen_ids[$urandom_range(TBL_DEPTH - 1)];
		else if (r < 70)
			prev = 8'($urandom_range(7));
		else if (r < 85)
			prev = 8'd0;
		else
			prev = 8'($urandom);
		return mk_resolve(pick_coord(1200), pick_coord(1200), prev);
	endfunction

	task automatic queue_word(req_t w, bit drain);
		pend_t p;
		p.w = w;
		p.drain = drain;
		pend_q.push_back(p);
	endtask

	task automatic run_random(int count, bit hold_first);
		@(negedge clk);
		for (int k = 0; k < count; k++)
			queue_word(($urandom_range(99) < 30) ? rand_zone_write() : rand_point(),
				(k == 0 && hold_first) || $urandom_range(199) == 0);
	endtask

	task automatic drain_all();
		while (pend_q.size() != 0 || req_valid || classes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ROOM_MIN_X: room_x0 = val;
			CFG_ROOM_MAX_X: room_x1 = val;
			CFG_ROOM_MIN_Y: room_y0 = val;
			CFG_ROOM_MAX_Y: room_y1 = val;
			CFG_ACTIVE_ZONES: scan_len = val[4:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_room(logic [31:0] x0, logic [31:0] x1, logic [31:0] y0,
			logic [31:0] y1, logic [4:0] n);
		cfg_write(CFG_ROOM_MIN_X, x0);
		cfg_write(CFG_ROOM_MAX_X, x1);
		cfg_write(CFG_ROOM_MIN_Y, y0);
		cfg_write(CFG_ROOM_MAX_Y, y1);
		cfg_write(CFG_ACTIVE_ZONES, {27'd0, n});
	endtask

	task automatic set_idle(int s, int r);
		@(posedge clk);
		send_idle_pct <= s;
		stall_pct <= r;
	endtask

	initial begin
		for (int i = 0; i < TBL_DEPTH; i++) begin
			zone_tbl[i] = '0;
			gen_ids[i] = 8'd0;
		end
		room_x0 = '0;
		room_x1 = '0;
		room_y0 = '0;
		room_y1 = '0;
		scan_len = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words over the full coordinate range
		set_room(MIN_MM, MAX_MM, MIN_MM, MAX_MM, 5'd16);
		@(negedge clk);
		queue_word(mk_resolve(0, 0, 0), 0);
		queue_word(mk_write(0, 1, 5, KIND_FIRST_USER, 20, 0, 100, 0, 100), 0);
		queue_word(mk_write(1, 1, 9, KIND_IGNORE, 0, 200, 300, 0, 100), 0);
		queue_word(mk_write(2, 1, 0, KIND_FIRST_USER + 3'd1, 0, 400, 500, 0, 100), 0);
		queue_word(mk_write(3, 1, 5, KIND_FIRST_USER + 3'd2, 0, -100, -50, 0, 100), 0);
		queue_word(mk_write(4, 0, 7, KIND_FIRST_USER + 3'd3, 0, 600, 700, 0, 100), 0);
		// empty rectangle that only the widest margin opens up
		queue_word(mk_write(5, 1, 12, KIND_FIRST_USER + 3'd4, 16'hffff, 900, 800, 0, 100), 0);
		queue_word(mk_write(15, 1, 255, KIND_FIRST_USER + 3'd5, 0,
			MIN_MM, MAX_MM, MIN_MM, MAX_MM), 0);
		queue_word(mk_write(6, 1, 20, KIND_IGNORE, 0, 32'h7fff_fd00, MAX_MM,
			32'h7fff_fd00, MAX_MM), 0);
		queue_word(mk_resolve(50, 50, 0), 0);
		queue_word(mk_resolve(110, 50, 5), 0);
		queue_word(mk_resolve(110, 50, 0), 0);
		queue_word(mk_resolve(250, 50, 5), 0);
		queue_word(mk_resolve(450, 50, 0), 0);
		queue_word(mk_resolve(650, 50, 7), 0);
		queue_word(mk_resolve(850, 50, 12), 0);
		queue_word(mk_resolve(850, 50, 0), 0);
		// duplicate id: first entry misses, scan finds the second
		queue_word(mk_resolve(-75, 50, 5), 0);
		queue_word(mk_resolve(MAX_MM, MAX_MM, 255), 0);
		queue_word(mk_resolve(MIN_MM, MIN_MM, 255), 0);
		queue_word(mk_resolve(MAX_MM, MIN_MM, 200), 0);
		queue_word(mk_write(1, 0, 9, KIND_IGNORE, 0, 200, 300, 0, 100), 0);
		queue_word(mk_resolve(250, 50, 0), 0);
		drain_all();

		// small room, short scan
		set_room(0, 1000, 0, 1000, 5'd3);
		@(negedge clk);
		queue_word(mk_resolve(1001, 50, 0), 0);
		queue_word(mk_resolve(50, -1, 5), 0);
		queue_word(mk_resolve(1000, 1000, 0), 0);
		queue_word(mk_resolve(50, 50, 5), 0);
		queue_word(mk_resolve(850, 50, 12), 0);
		drain_all();

		set_room(-1000, 1000, -1000, 1000, 5'd16);
		run_random(300, 0);
		drain_all();

		set_idle(67, 0);
		set_room(srange(-1100, -200), srange(200, 1100), srange(-1100, -200),
			srange(200, 1100), 5'd31);
		run_random(300, 1);
		drain_all();

		set_idle(0, 67);
		set_room(srange(-1100, -200), srange(200, 1100), srange(-1100, -200),
			srange(200, 1100), 5'($urandom_range(1, 15)));
		run_random(300, 0);
		drain_all();

		set_idle(7, 7);
		set_room(srange(-1100, -200), srange(200, 1100), srange(-1100, -200),
			srange(200, 1100), 5'd17);
		run_random(300, 1);
		drain_all();

		// room empty in x, then no zones scanned at all
		set_room(500, -500, -300, 300, 5'd0);
		run_random(30, 0);
		drain_all();
		set_room(-1000, 1000, -1000, 1000, 5'd0);
		run_random(30, 0);
		drain_all();

		$display("covered %0d zone writes and %0d point resolves, %0d in area, %0d in a zone",
			n_writes, n_resolves, n_in_area, n_zoned);
		$display("room and scan settings from empty to full range, scan lengths 0 to 31");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout: results still outstanding");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
hw/rtl/rzc_pkg.sv
hw/rtl/rzc_table.sv
hw/rtl/rzc_cmp.sv
hw/rtl/rect_zone_classifier.sv
bench/tb_top.sv
